// File: src/fbct_pkg.sv
// Shared types and constants of the flow byte counter table.
package fbct_pkg;

   // Reset value of the entry limit register.
   localparam logic [6:0] LIMIT_RESET = 7'd100;

   // Largest count the eviction field can show.
   localparam logic [6:0] EVICT_MAX = 7'd127;

   // One input word.
   typedef struct packed {
      logic [63:0] flow_key;
      logic [15:0] read_bytes;
      logic [15:0] write_bytes;
      logic [31:0] now_seconds;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [63:0] entry_read_total;
      logic [63:0] entry_write_total;
      logic        was_new;
      logic [6:0]  evict_count;
      logic [63:0] evicted_key;
      logic [7:0]  entries_in_use;
      logic [31:0] entries_ever;
      logic [63:0] total_read;
      logic [63:0] total_write;
   } rsp_word_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_MIN,
      ST_EVICT,
      ST_WRITE
   } state_type;

endpackage

// File: src/fbct_if.sv
// Valid/ready channel interfaces for request and response words.
interface fbct_req_if;
   logic                      valid;
   logic                      ready;
   fbct_pkg::req_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fbct_rsp_if;
   logic                      valid;
   logic                      ready;
   fbct_pkg::rsp_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/fbct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/flow_byte_counter_table_core.sv
// Flow byte counter table: sequencer around one entry RAM with least-used eviction.
// A known key gives its result after one search pass over the table.
// A new key adds one minimum scan for each entry evicted.
// One word at a time; the next word is taken in the cycle after the result is written.
// Reset (synchronous, active high) clears valid bits, counters, totals and sets limit to 100.
module flow_byte_counter_table_core #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   fbct_req_if.sink    req_chan,
   fbct_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int REC_W = KEY_BITS + 64 + 64 + 32 + 32;
   localparam int RC_LO = KEY_BITS;
   localparam int WC_LO = KEY_BITS + 64;
   localparam int LT_LO = KEY_BITS + 128;
   localparam int SQ_LO = KEY_BITS + 160;

   fbct_pkg::state_type state_ff, state_in;
   logic [6:0]          limit_ff, limit_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                chk_on_ff, chk_on_in;
   logic                chk_min_ff, chk_min_in;
   logic [AW-1:0]       chk_idx_ff, chk_idx_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [15:0]         rb_ff, rb_in, wb_ff, wb_in;
   logic [31:0]         now_ff, now_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [63:0]         hit_rc_ff, hit_rc_in, hit_wc_ff, hit_wc_in;
   logic [31:0]         hit_lt_ff, hit_lt_in, hit_sq_ff, hit_sq_in;
   logic                free_vld_ff, free_vld_in;
   logic [AW-1:0]       free_ff, free_in;
   logic                have_ff, have_in;
   logic [AW-1:0]       best_ff, best_in;
   logic [63:0]         bsum_ff, bsum_in;
   logic [31:0]         blt_ff, blt_in, bage_ff, bage_in;
   logic [KEY_BITS-1:0] bkey_ff, bkey_in;
   logic [6:0]          evc_ff, evc_in;
   logic [63:0]         ekey_ff, ekey_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [31:0]         ever_ff, ever_in, seq_ff, seq_in;
   logic [63:0]         sum_r_ff, sum_r_in, sum_w_ff, sum_w_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                rsp_vld_ff, rsp_vld_in;
   fbct_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [REC_W-1:0]    wr_data, rd_data;

   // Fields of the entry coming back from the RAM.
   logic [KEY_BITS-1:0] rd_key;
   logic [63:0]         rd_rc, rd_wc, rd_sum;
   logic [31:0]         rd_lt, rd_sq, rd_age;
   logic                rd_vld, better;
   logic [31:0]         limit_eff;
   logic [63:0]         base_rc, base_wc, new_rc, new_wc;
   logic [31:0]         base_lt, new_lt, new_sq;
   logic [AW-1:0]       tgt;

   assign rd_key = rd_data[KEY_BITS-1:0];
   assign rd_rc  = rd_data[RC_LO +: 64];
   assign rd_wc  = rd_data[WC_LO +: 64];
   assign rd_lt  = rd_data[LT_LO +: 32];
   assign rd_sq  = rd_data[SQ_LO +: 32];
   assign rd_sum = rd_rc + rd_wc;
   assign rd_age = seq_ff - rd_sq;
   assign rd_vld = valid_ff[chk_idx_ff];

   // Victim ranking: smaller sum, then older time, then most recent insert.
   assign better = !have_ff || (rd_sum < bsum_ff)
      || ((rd_sum == bsum_ff) && (rd_lt < blt_ff))
      || ((rd_sum == bsum_ff) && (rd_lt == blt_ff) && (rd_age < bage_ff));

   // Effective limit is capped at TABLE_DEPTH - 1, so a new key always gets a free entry after eviction.
   assign limit_eff = (32'(limit_ff) > 32'(TABLE_DEPTH - 1)) ?
                      32'(TABLE_DEPTH - 1) : 32'(limit_ff);

   // Entry written back by the final step.
   assign base_rc = found_ff ? hit_rc_ff : 64'd0;
   assign base_wc = found_ff ? hit_wc_ff : 64'd0;
   assign base_lt = found_ff ? hit_lt_ff : 32'd0;
   assign new_sq  = found_ff ? hit_sq_ff : seq_ff;
   assign tgt     = found_ff ? slot_ff : free_ff;
   assign new_rc  = base_rc + 64'(rb_ff);
   assign new_wc  = base_wc + 64'(wb_ff);
   assign new_lt  = ((33'(base_lt) + 33'd1) < 33'(now_ff)) ? now_ff : base_lt;
   assign wr_data = {new_sq, new_lt, new_wc, new_rc, key_ff};
   assign wr_addr = tgt;

   fbct_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == fbct_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Next-state and datapath logic of the sequencer.
   always_comb begin
      state_in = state_ff;  limit_in = limit_ff;  cnt_in = cnt_ff;
      chk_on_in = 1'b0;  chk_min_in = chk_min_ff;  chk_idx_in = chk_idx_ff;
      key_in = key_ff;  rb_in = rb_ff;  wb_in = wb_ff;  now_in = now_ff;
      found_in = found_ff;  slot_in = slot_ff;
      hit_rc_in = hit_rc_ff;  hit_wc_in = hit_wc_ff;
      hit_lt_in = hit_lt_ff;  hit_sq_in = hit_sq_ff;
      free_vld_in = free_vld_ff;  free_in = free_ff;
      have_in = have_ff;  best_in = best_ff;  bsum_in = bsum_ff;
      blt_in = blt_ff;  bage_in = bage_ff;  bkey_in = bkey_ff;
      evc_in = evc_ff;  ekey_in = ekey_ff;  used_in = used_ff;
      ever_in = ever_ff;  seq_in = seq_ff;
      sum_r_in = sum_r_ff;  sum_w_in = sum_w_ff;  valid_in = valid_ff;
      rsp_vld_in = rsp_vld_ff;  rsp_data_in = rsp_data_ff;
      rd_addr = cnt_ff[AW-1:0];
      wr_en = 1'b0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      // Compare stage: one RAM entry checked per cycle.
      if (chk_on_ff) begin
         if (!chk_min_ff) begin
            if (rd_vld && (rd_key == key_ff) && !found_ff) begin
               found_in = 1'b1;  slot_in = chk_idx_ff;
               hit_rc_in = rd_rc;  hit_wc_in = rd_wc;
               hit_lt_in = rd_lt;  hit_sq_in = rd_sq;
            end
            if (!rd_vld && !free_vld_ff) begin
               free_vld_in = 1'b1;  free_in = chk_idx_ff;
            end
         end else if (rd_vld && better) begin
            have_in = 1'b1;  best_in = chk_idx_ff;  bsum_in = rd_sum;
            blt_in = rd_lt;  bage_in = rd_age;  bkey_in = rd_key;
         end
      end

      unique case (state_ff) inside
         fbct_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               key_in = req_chan.data.flow_key[KEY_BITS-1:0];
               rb_in = req_chan.data.read_bytes;
               wb_in = req_chan.data.write_bytes;
               now_in = req_chan.data.now_seconds;
               sum_r_in = sum_r_ff + 64'(req_chan.data.read_bytes);
               sum_w_in = sum_w_ff + 64'(req_chan.data.write_bytes);
               found_in = 1'b0;  free_vld_in = 1'b0;
               evc_in = '0;  ekey_in = '0;  cnt_in = '0;
               chk_min_in = 1'b0;
               state_in = fbct_pkg::ST_SEARCH;
            end
         end
         fbct_pkg::ST_SEARCH, fbct_pkg::ST_MIN: begin
            if (cnt_ff < CW'(TABLE_DEPTH)) begin
               chk_on_in = 1'b1;
               chk_idx_in = cnt_ff[AW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end else begin
               state_in = (state_ff == fbct_pkg::ST_SEARCH) ?
                          fbct_pkg::ST_DECIDE : fbct_pkg::ST_EVICT;
            end
         end
         fbct_pkg::ST_DECIDE: begin
            if (!found_ff && (32'(used_ff) > limit_eff)) begin
               have_in = 1'b0;  cnt_in = '0;  chk_min_in = 1'b1;
               state_in = fbct_pkg::ST_MIN;
            end else begin
               state_in = fbct_pkg::ST_WRITE;
            end
         end
         fbct_pkg::ST_EVICT: begin
            if (have_ff) begin
               valid_in[best_ff] = 1'b0;
               used_in = used_ff - CW'(1);
               if (evc_ff == 7'd0) begin
                  ekey_in = 64'(bkey_ff);
               end
               if (evc_ff != fbct_pkg::EVICT_MAX) begin
                  evc_in = evc_ff + 7'd1;
               end
               if (!free_vld_ff || (best_ff < free_ff)) begin
                  free_vld_in = 1'b1;  free_in = best_ff;
               end
               state_in = fbct_pkg::ST_DECIDE;
            end else begin
               state_in = fbct_pkg::ST_WRITE;
            end
         end
         fbct_pkg::ST_WRITE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               wr_en = 1'b1;
               if (!found_ff) begin
                  valid_in[tgt] = 1'b1;
                  used_in = used_ff + CW'(1);
                  ever_in = ever_ff + 32'd1;
                  seq_in = seq_ff + 32'd1;
               end
               rsp_vld_in = 1'b1;
               rsp_data_in.entry_read_total = new_rc;
               rsp_data_in.entry_write_total = new_wc;
               rsp_data_in.was_new = !found_ff;
               rsp_data_in.evict_count = evc_ff;
               rsp_data_in.evicted_key = ekey_ff;
               rsp_data_in.entries_in_use = 8'(used_in);
               rsp_data_in.entries_ever = ever_in;
               rsp_data_in.total_read = sum_r_ff;
               rsp_data_in.total_write = sum_w_ff;
               state_in = fbct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbct_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbct_pkg::ST_IDLE;
         limit_ff <= fbct_pkg::LIMIT_RESET;
         chk_on_ff <= 1'b0;
         valid_ff <= '0;
         used_ff <= '0;
         ever_ff <= '0;
         seq_ff <= '0;
         sum_r_ff <= '0;
         sum_w_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         chk_on_ff <= chk_on_in;
         valid_ff <= valid_in;
         used_ff <= used_in;
         ever_ff <= ever_in;
         seq_ff <= seq_in;
         sum_r_ff <= sum_r_in;
         sum_w_ff <= sum_w_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Working registers of the current word.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;  chk_min_ff <= chk_min_in;  chk_idx_ff <= chk_idx_in;
      key_ff <= key_in;  rb_ff <= rb_in;  wb_ff <= wb_in;  now_ff <= now_in;
      found_ff <= found_in;  slot_ff <= slot_in;
      hit_rc_ff <= hit_rc_in;  hit_wc_ff <= hit_wc_in;
      hit_lt_ff <= hit_lt_in;  hit_sq_ff <= hit_sq_in;
      free_vld_ff <= free_vld_in;  free_ff <= free_in;
      have_ff <= have_in;  best_ff <= best_in;  bsum_ff <= bsum_in;
      blt_ff <= blt_in;  bage_ff <= bage_in;  bkey_ff <= bkey_in;
      evc_ff <= evc_in;  ekey_ff <= ekey_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: src/fbct_checker.sv
// Port-level assertions for the flow byte counter table and their binding.
module fbct_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fbct_pkg::rsp_word_type rsp_data
);

   // A pending response word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A stalled response word keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response word changed while stalled");

   // Only an insertion can evict entries.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_new |->
         (rsp_data.evict_count == 7'd0) && (rsp_data.evicted_key == 64'd0))
      else $error("eviction reported for a known key");

   // No response word right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response offered after reset");

endmodule

bind flow_byte_counter_table_core fbct_checker u_fbct_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
